/* rtl/sfse_pkg.sv */
// shared constants for the sensor frame sync extractor
package sfse_pkg;

  // default frame length in bytes
  localparam int FRAME_BYTES_DEF = 32;

  // two-byte frame header, oldest byte first
  localparam logic [7:0] HEAD_FIRST  = 8'h42;
  localparam logic [7:0] HEAD_SECOND = 8'h4D;

  // result words and their big-endian byte offsets within a frame
  localparam int NUM_WORDS = 6;
  localparam int WORD_W    = 16;
  localparam int OUT_W     = NUM_WORDS * WORD_W;
  localparam int WORD_OFS [NUM_WORDS] = '{6, 8, 12, 14, 24, 26};

endpackage

/* rtl/sensor_frame_sync_extractor_top.sv */
// sensor frame sync extractor: header search and field extraction over a byte window
//
// Input channel s_axis_*: one received serial byte per word.
// Output channel m_axis_*: one word per detected frame, carrying six 16-bit
// big-endian fields taken from frame byte offsets 6, 8, 12, 14, 24 and 26.
// The block keeps the last FRAME_BYTES bytes in a shift register and a fill
// count. When the byte that fills the window is accepted and the two oldest
// bytes are 0x42 0x4D, a result is loaded and the window empties; otherwise
// the oldest byte falls out and the window slides by one.
// The result is registered: it is valid in the cycle after the completing byte is accepted.
// Throughput: one byte per cycle unless a held result stalls input; the shift,
// header compare and field select all sit between the window and output registers.
// Reset clears the fill count and the output valid flag; window bytes are
// left as they are and are never read before being written.
// When the receiver stalls, the result is held in the output register and
// input bytes wait; a byte can be taken in the same cycle the result is taken.
module sensor_frame_sync_extractor_top
  import sfse_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // rx_byte
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // dust_a, dust_b, dust_c, dust_d, temperature_raw, humidity_raw (lowest first)
  output logic [OUT_W-1:0] m_axis_tdata
);

  localparam int CNT_W = $clog2(FRAME_BYTES);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(FRAME_BYTES - 1);

  logic [7:0]       window     [FRAME_BYTES];
  logic [7:0]       window_next[FRAME_BYTES];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             in_acc;
  logic             frame_hit;
  logic [OUT_W-1:0] fields;

  // handshake: input flows whenever the output register is free or draining
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // window after shifting in the new byte, newest at the top
  always_comb begin
    for (int i = 0; i < FRAME_BYTES - 1; i++) begin
      window_next[i] = window[i + 1];
    end
    window_next[FRAME_BYTES - 1] = s_axis_tdata;
  end

  // header check on the full window
  assign frame_hit = (count == LAST_CNT) &&
                     (window_next[0] == HEAD_FIRST) &&
                     (window_next[1] == HEAD_SECOND);

  // field select from fixed frame offsets
  always_comb begin
    for (int k = 0; k < NUM_WORDS; k++) begin
      fields[k*WORD_W +: WORD_W] = {window_next[WORD_OFS[k]], window_next[WORD_OFS[k] + 1]};
    end
  end

  // fill count: saturates one below full unless a frame empties the window
  always_comb begin
    if (count == LAST_CNT) begin
      count_next = frame_hit ? '0 : LAST_CNT;
    end else begin
      count_next = count + 1'b1;
    end
  end

  // window shift register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
        window[i] <= window_next[i];
      end
    end
  end

  // fill count register
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_acc) begin
      count <= count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_acc && frame_hit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && frame_hit) begin
      m_axis_tdata <= fields;
    end
  end

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    int'(count) < FRAME_BYTES)
    else $error("fill count reached frame length");

  a_hit_empties: assert property (@(posedge clk) disable iff (rst)
    in_acc && frame_hit |=> count == '0 && m_axis_tvalid)
    else $error("frame hit did not empty window or raise result");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(in_acc) && $past(frame_hit))
    else $error("result raised without a completed frame");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) && !rst |-> !m_axis_tvalid && count == '0)
    else $error("state not cleared by reset");

endmodule
